// ===== design/sfr_pkg.sv =====
// Shared types and constants for the sensor frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int FRAME_LEN     = 9;
  localparam int POS_W         = 4;
  localparam int OUT_CNT_W     = 16;
  localparam int READING_W     = 16;
  localparam logic [7:0] READ_COMMAND = 8'h86;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  localparam int EVENT_FIFO_DEPTH = 2;
  localparam int EVENT_FIFO_AW    = $clog2(EVENT_FIFO_DEPTH);

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_BAD_CMD = 2'd2
  } frame_status_e;

  // One finished frame, as handed from the front end to the back end.
  typedef struct packed {
    frame_status_e          status;
    logic [READING_W-1:0]   reading;
  } frame_event_t;

endpackage

`default_nettype wire

// ===== design/sfr_front.sv =====
// Front end: frames incoming bytes, checks the checksum and classifies frames.
`timescale 1ns / 1ps
`default_nettype none

module sfr_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 beat_i,
  input  wire logic [7:0]           rx_byte_i,
  input  wire logic                 frame_restart_i,
  output sfr_pkg::frame_event_t     event_o,
  output logic                      push_o
);

  logic [sfr_pkg::POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]                sum_q, sum_d, sum_eff;
  logic [7:0]                cmd_q, cmd_d;
  logic [7:0]                hi_q, hi_d;
  logic [7:0]                lo_q, lo_d;
  logic                      last_byte;
  logic [7:0]                expect_sum;

  // A restart clears position and sum before this byte is taken.
  assign pos_eff    = frame_restart_i ? '0 : pos_q;
  assign sum_eff    = frame_restart_i ? '0 : sum_q;
  assign last_byte  = (pos_eff >= sfr_pkg::LAST_POS);
  assign expect_sum = 8'(~sum_eff + 8'd1);

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    cmd_d = cmd_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (beat_i) begin
      if (last_byte) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_eff + 1'b1;
        sum_d = (pos_eff != '0) ? 8'(sum_eff + rx_byte_i) : sum_eff;
        if (pos_eff == sfr_pkg::POS_W'(1)) cmd_d = rx_byte_i;
        if (pos_eff == sfr_pkg::POS_W'(2)) hi_d  = rx_byte_i;
        if (pos_eff == sfr_pkg::POS_W'(3)) lo_d  = rx_byte_i;
      end
    end
  end

  always_comb begin
    push_o          = beat_i && last_byte;
    event_o.reading = {hi_q, lo_q};
    if (expect_sum != rx_byte_i) begin
      event_o.status = sfr_pkg::STATUS_BAD_SUM;
    end else if (cmd_q == sfr_pkg::READ_COMMAND) begin
      event_o.status = sfr_pkg::STATUS_GOOD;
    end else begin
      event_o.status = sfr_pkg::STATUS_BAD_CMD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Fields are always rewritten at positions 1..3 before a frame completes.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

endmodule

`default_nettype wire

// ===== design/sfr_event_fifo.sv =====
// Short queue of classified frames between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sfr_event_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire sfr_pkg::frame_event_t data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output sfr_pkg::frame_event_t     data_o,
  output logic                      empty_o
);

  localparam int AW = sfr_pkg::EVENT_FIFO_AW;
  localparam int DEPTH = sfr_pkg::EVENT_FIFO_DEPTH;

  sfr_pkg::frame_event_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

// ===== design/sfr_back.sv =====
// Back end: updates reading and counters per frame and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none

module sfr_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sfr_pkg::frame_event_t           event_i,
  input  wire logic                            empty_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output sfr_pkg::frame_status_e               frame_status_o,
  output logic [sfr_pkg::READING_W-1:0]        concentration_o,
  output logic [sfr_pkg::OUT_CNT_W-1:0]        good_frames_o,
  output logic [sfr_pkg::OUT_CNT_W-1:0]        checksum_failures_o,
  output logic [sfr_pkg::OUT_CNT_W-1:0]        command_failures_o
);

  localparam int CW = sfr_pkg::COUNTER_WIDTH;

  logic                           valid_q;
  logic [sfr_pkg::READING_W-1:0]  reading_q, reading_d;
  logic [CW-1:0]                  good_q, good_d;
  logic [CW-1:0]                  bad_sum_q, bad_sum_d;
  logic [CW-1:0]                  bad_cmd_q, bad_cmd_d;
  sfr_pkg::frame_status_e         status_q;

  // Output register frees up when empty or when its beat is taken.
  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_comb begin
    reading_d = reading_q;
    good_d    = good_q;
    bad_sum_d = bad_sum_q;
    bad_cmd_d = bad_cmd_q;
    unique case (event_i.status)
      sfr_pkg::STATUS_GOOD: begin
        reading_d = event_i.reading;
        good_d    = good_q + 1'b1;
      end
      sfr_pkg::STATUS_BAD_SUM: bad_sum_d = bad_sum_q + 1'b1;
      sfr_pkg::STATUS_BAD_CMD: bad_cmd_d = bad_cmd_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      reading_q <= '0;
      good_q    <= '0;
      bad_sum_q <= '0;
      bad_cmd_q <= '0;
    end else begin
      if (pop_o) begin
        valid_q   <= 1'b1;
        reading_q <= reading_d;
        good_q    <= good_d;
        bad_sum_q <= bad_sum_d;
        bad_cmd_q <= bad_cmd_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) status_q <= event_i.status;
  end

  assign out_valid_o         = valid_q;
  assign frame_status_o      = status_q;
  assign concentration_o     = reading_q;
  assign good_frames_o       = sfr_pkg::OUT_CNT_W'(good_q);
  assign checksum_failures_o = sfr_pkg::OUT_CNT_W'(bad_sum_q);
  assign command_failures_o  = sfr_pkg::OUT_CNT_W'(bad_cmd_q);

endmodule

`default_nettype wire

// ===== design/sensor_frame_receiver.sv =====
// Top level of the sensor frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Groups received bytes into fixed 9-byte frames (no start-byte search; a
// restart flag on a beat drops any partial frame and makes that byte the
// first of a new one). Byte 8 must equal the negated 8-bit sum of bytes 1..7;
// a good frame with command 0x86 updates the 16-bit reading from bytes 2/3.
// One result beat per frame carries the status, the latest reading and the
// three wrapping frame counters. Input bytes are taken one per cycle; the
// front end stalls only when its two-entry frame queue is full, which needs
// the result side to stall for more than a frame. After the ninth byte is
// taken, a result is written to the queue, then to the output register.
module sensor_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] frame_restart
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] frame_status, [17:2] concentration, [33:18] good_frames,
  // [49:34] checksum_failures, [65:50] command_failures, [71:66] zero
  output logic [71:0]      m_axis_tdata_o
);

  sfr_pkg::frame_event_t  front_event, back_event;
  logic                   push, pop, full, empty, beat;
  sfr_pkg::frame_status_e status;
  logic [sfr_pkg::READING_W-1:0] concentration;
  logic [sfr_pkg::OUT_CNT_W-1:0] good_frames, checksum_failures, command_failures;

  assign s_axis_tready_o = !full;
  assign beat            = s_axis_tvalid_i && s_axis_tready_o;

  sfr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .rx_byte_i      (s_axis_tdata_i),
    .frame_restart_i(s_axis_tuser_i),
    .event_o        (front_event),
    .push_o         (push)
  );

  sfr_event_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (front_event),
    .full_o (full),
    .pop_i  (pop),
    .data_o (back_event),
    .empty_o(empty)
  );

  sfr_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .event_i            (back_event),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .frame_status_o     (status),
    .concentration_o    (concentration),
    .good_frames_o      (good_frames),
    .checksum_failures_o(checksum_failures),
    .command_failures_o (command_failures)
  );

  assign m_axis_tdata_o = {6'd0, command_failures, checksum_failures, good_frames,
                           concentration, status};

endmodule

`default_nettype wire
